>>> rtl/core/scoped_name_hash_index_defines.svh
// ----------------------------------------------------------------------------
// Scoped name hash index assertion macros
// Shared property templates. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SCOPED_NAME_HASH_INDEX_DEFINES_SVH
`define SCOPED_NAME_HASH_INDEX_DEFINES_SVH

// Same-cycle implication.
`define SNHI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SNHI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/snhi_pkg.sv
// ----------------------------------------------------------------------------
// Scoped name hash index package
// Widths, hash constants, operation codes and controller/datapath types.
// ----------------------------------------------------------------------------
package snhi_pkg;

    localparam int OP_W         = 2;
    localparam int SCOPE_W      = 64;
    localparam int NAME_W       = 32;
    localparam int SLOT_W       = 10;
    localparam int SIZE_W       = 4;
    localparam int IN_TDATA_W   = 104;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_PAD_W    = OUT_TDATA_W - (SLOT_W + 3);

    localparam int OP_LSB       = 0;
    localparam int SCOPE_LSB    = OP_LSB + OP_W;
    localparam int NAME_LSB     = SCOPE_LSB + SCOPE_W;

    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int SIZE_LOG2_MIN       = 4;
    localparam int SIZE_LOG2_MAX       = 10;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = SIZE_W'(10);

    localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

    localparam int COMBINE_SHL = 6;
    localparam int COMBINE_SHR = 2;
    localparam int FOLD_A      = 30;
    localparam int FOLD_B      = 27;
    localparam int FOLD_C      = 31;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND     = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [NAME_W-1:0] NAME_RESERVED = '1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MIX,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MA3,
        ST_XB,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_MB3,
        ST_HOME,
        ST_READ,
        ST_CMP
    } ctrl_state_t;

    typedef enum logic [1:0] {
        X_HOLD,
        X_MIX,
        X_FROM_ACC
    } x_op_t;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_HL,
        MUL_LH
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } acc_op_t;

    typedef struct packed {
        logic              dup;
        logic [SCOPE_W-1:0] scope;
        logic [NAME_W-1:0]  key;
    } slot_entry_t;

    typedef struct packed {
        logic     load;
        logic     sweep;
        x_op_t    x_op;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mix_b;
        acc_op_t  acc_op;
        logic     probe_start;
        logic     mem_read;
        logic     probe_eval;
        logic     probe_next;
        logic     out_load;
    } snhi_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic in_skip;
        logic empty_hit;
        logic match_hit;
        logic last_probe;
        logic sweep_last;
        logic out_busy;
    } snhi_sts_t;

endpackage

>>> rtl/core/scoped_name_hash_index.sv
// ----------------------------------------------------------------------------
// Scoped name hash index: linear probing hash set over a scope and name key.
// Insert or find: the key is mixed, then the slots are probed one after another
// from the home slot. Clear sweeps every slot empty; a skipped beat only returns
// a result. One operation is in flight at a time: the next beat is taken once
// the result has been handed to the output register.
// After reset a sweep writes all 2^ADDR_W slots (1024 by default) empty.
// ----------------------------------------------------------------------------
`include "scoped_name_hash_index_defines.svh"

module scoped_name_hash_index
    import snhi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SIZE_W-1:0]      cfg_data,   // size_log2
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // op[1:0], scope_key[65:2], name_id[97:66]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata     // found[0], duplicated[1],
                                               // slot_index[11:2], table_full[12]
);

    localparam int FLOOR_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int ADDR_W     = (FLOOR_LOG2 < SIZE_LOG2_MAX) ? FLOOR_LOG2 : SIZE_LOG2_MAX;

    snhi_cmd_t cmd;
    snhi_sts_t sts;
    logic      done_state;

    assign cfg_ready = 1'b1;

    snhi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sts        (sts),
        .cmd        (cmd),
        .done_state (done_state)
    );

    snhi_datapath #(
        .ADDR_W (ADDR_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `SNHI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input accepted while an operation was still running")
    `SNHI_ASSERT_SAME(a_no_result_overwrite, cmd.out_load, !(m_tvalid && !m_tready),
        "pending result overwritten")
    `SNHI_ASSERT_SAME(a_probe_stops, cmd.probe_next, !(sts.empty_hit || sts.match_hit),
        "probe stepped past an empty or matching slot")
    `SNHI_ASSERT_SAME(a_full_fields, m_tvalid && m_tdata[12], m_tdata[11:0] == 12'd0,
        "full result carries a slot or a hit")
    `SNHI_ASSERT_SAME(a_done_no_sweep, done_state, !cmd.sweep && !s_tready,
        "result hand-off overlaps a sweep or an accept")

endmodule

>>> rtl/core/snhi_ctrl.sv
// ----------------------------------------------------------------------------
// Scoped name hash index controller
// Sequences clearing sweeps, the hash mixer steps and the slot probe loop.
// ----------------------------------------------------------------------------
module snhi_ctrl
    import snhi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  snhi_sts_t sts,
    output snhi_cmd_t cmd,
    output logic      done_state
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        if (done_reg)
        begin
            if (!sts.out_busy)
            begin
                done_next  = 1'b0;
                state_next = ST_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                ST_INIT:
                begin
                    if (sts.sweep_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (sts.in_clear)
                        begin
                            state_next = ST_CLEAR;
                        end
                        else if (sts.in_skip)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_MIX;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    if (sts.sweep_last)
                    begin
                        done_next = 1'b1;
                    end
                end
                ST_MIX:  state_next = ST_MA0;
                ST_MA0:  state_next = ST_MA1;
                ST_MA1:  state_next = ST_MA2;
                ST_MA2:  state_next = ST_MA3;
                ST_MA3:  state_next = ST_XB;
                ST_XB:   state_next = ST_MB0;
                ST_MB0:  state_next = ST_MB1;
                ST_MB1:  state_next = ST_MB2;
                ST_MB2:  state_next = ST_MB3;
                ST_MB3:  state_next = ST_HOME;
                ST_HOME: state_next = ST_READ;
                ST_READ: state_next = ST_CMP;
                ST_CMP:
                begin
                    if (sts.empty_hit || sts.match_hit || sts.last_probe)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
                default: state_next = ST_INIT;
            endcase
        end
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        done_state = done_reg;
        if (done_reg)
        begin
            cmd.out_load = !sts.out_busy;
        end
        else
        begin
            case (state_reg)
                ST_INIT:
                begin
                    cmd.sweep = 1'b1;
                end
                ST_IDLE:
                begin
                    s_tready = 1'b1;
                    cmd.load = s_tvalid;
                end
                ST_CLEAR:
                begin
                    cmd.sweep = 1'b1;
                end
                ST_MIX:
                begin
                    cmd.x_op = X_MIX;
                end
                ST_MA0, ST_MB0:
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_LL;
                    cmd.mix_b   = (state_reg == ST_MB0);
                end
                ST_MA1, ST_MB1:
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_HL;
                    cmd.mix_b   = (state_reg == ST_MB1);
                    cmd.acc_op  = ACC_LOAD;
                end
                ST_MA2, ST_MB2:
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_LH;
                    cmd.mix_b   = (state_reg == ST_MB2);
                    cmd.acc_op  = ACC_ADD_HI;
                end
                ST_MA3, ST_MB3:
                begin
                    cmd.acc_op = ACC_ADD_HI;
                end
                ST_XB:
                begin
                    cmd.x_op = X_FROM_ACC;
                end
                ST_HOME:
                begin
                    cmd.probe_start = 1'b1;
                end
                ST_READ:
                begin
                    cmd.mem_read = 1'b1;
                end
                ST_CMP:
                begin
                    cmd.probe_eval = 1'b1;
                    cmd.probe_next = !(sts.empty_hit || sts.match_hit || sts.last_probe);
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/snhi_datapath.sv
// ----------------------------------------------------------------------------
// Scoped name hash index datapath
// Key registers, shared 32x32 multiplier, slot memory, probe counters and
// the result register.
// ----------------------------------------------------------------------------
module snhi_datapath
    import snhi_pkg::*;
#(
    parameter int ADDR_W = SIZE_LOG2_MAX
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   cfg_we,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  snhi_cmd_t              cmd,
    output snhi_sts_t              sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH = 1 << ADDR_W;

    slot_entry_t mem [DEPTH];

    logic [SIZE_W-1:0]  size_reg;
    logic [OP_W-1:0]    op_reg;
    logic [SCOPE_W-1:0] scope_reg;
    logic [NAME_W-1:0]  name_reg;
    logic [63:0]        x_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic [ADDR_W-1:0]  probe_reg;
    logic [ADDR_W-1:0]  visited_reg;
    logic [ADDR_W-1:0]  sweep_reg;
    slot_entry_t        rd_reg;
    logic               res_found_reg;
    logic               res_dup_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               res_full_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic               out_dup_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_full_reg;

    logic [OP_W-1:0]    in_op;
    logic [NAME_W-1:0]  in_name;
    logic [SIZE_W-1:0]  size_eff;
    logic [ADDR_W:0]    mask_full;
    logic [ADDR_W-1:0]  mask;
    logic [NAME_W-1:0]  key;
    logic [63:0]        combined;
    logic [63:0]        x_next;
    logic [63:0]        mul_const;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_next;
    logic [63:0]        hash;
    logic               is_insert;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    slot_entry_t        wr_data;

    assign in_op   = s_tdata[OP_LSB +: OP_W];
    assign in_name = s_tdata[NAME_LSB +: NAME_W];

    always_comb
    begin
        if (size_reg < SIZE_W'(SIZE_LOG2_MIN))
        begin
            size_eff = SIZE_W'(SIZE_LOG2_MIN);
        end
        else if (size_reg > SIZE_W'(ADDR_W))
        begin
            size_eff = SIZE_W'(ADDR_W);
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    assign mask_full = ({{ADDR_W{1'b0}}, 1'b1} << size_eff) - (ADDR_W + 1)'(1);
    assign mask      = mask_full[ADDR_W-1:0];
    assign key       = name_reg + NAME_W'(1);
    assign is_insert = (op_reg == OP_INSERT);

    assign combined = scope_reg ^ ({{(64 - NAME_W){1'b0}}, name_reg} + GOLDEN_STEP
                      + (scope_reg << COMBINE_SHL) + (scope_reg >> COMBINE_SHR));

    always_comb
    begin
        case (cmd.x_op)
            X_MIX:      x_next = combined ^ (combined >> FOLD_A);
            X_FROM_ACC: x_next = acc_reg ^ (acc_reg >> FOLD_B);
            default:    x_next = x_reg;
        endcase
    end

    assign mul_const = cmd.mix_b ? MIX_MUL_B : MIX_MUL_A;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LL:
            begin
                mul_a = x_reg[31:0];
                mul_b = mul_const[31:0];
            end
            MUL_HL:
            begin
                mul_a = x_reg[63:32];
                mul_b = mul_const[31:0];
            end
            MUL_LH:
            begin
                mul_a = x_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {32'b0, mul_a} * {32'b0, mul_b};
    assign hash      = acc_reg ^ (acc_reg >> FOLD_C);

    assign sts.in_clear   = (in_op == OP_CLEAR);
    assign sts.in_skip    = (in_op == OP_RESERVED) || (in_name == NAME_RESERVED);
    assign sts.empty_hit  = (rd_reg.key == '0);
    assign sts.match_hit  = (rd_reg.key != '0) && (rd_reg.key == key)
                            && (rd_reg.scope == scope_reg);
    assign sts.last_probe = (visited_reg == mask);
    assign sts.sweep_last = (sweep_reg == {ADDR_W{1'b1}});
    assign sts.out_busy   = out_valid_reg && !m_tready;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = probe_reg;
        wr_data = '{dup: sts.match_hit, scope: scope_reg, key: key};
        if (cmd.sweep)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = '0;
        end
        else if (cmd.probe_eval && is_insert && (sts.match_hit || sts.empty_hit))
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_read)
        begin
            rd_reg <= mem[probe_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_LOG2_RESET;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= in_op;
            scope_reg     <= s_tdata[SCOPE_LSB +: SCOPE_W];
            name_reg      <= in_name;
            res_found_reg <= 1'b0;
            res_dup_reg   <= 1'b0;
            res_slot_reg  <= '0;
            res_full_reg  <= 1'b0;
        end
        x_reg <= x_next;
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        case (cmd.acc_op)
            ACC_LOAD:   acc_reg <= prod_reg;
            ACC_ADD_HI: acc_reg <= acc_reg + {prod_reg[31:0], 32'b0};
            default:    acc_reg <= acc_reg;
        endcase
        if (cmd.probe_start)
        begin
            probe_reg   <= hash[ADDR_W-1:0] & mask;
            visited_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            probe_reg   <= (probe_reg + ADDR_W'(1)) & mask;
            visited_reg <= visited_reg + ADDR_W'(1);
        end
        if (cmd.probe_eval)
        begin
            if (sts.match_hit)
            begin
                res_found_reg <= 1'b1;
                res_dup_reg   <= is_insert || rd_reg.dup;
                res_slot_reg  <= SLOT_W'(probe_reg);
            end
            else if (sts.empty_hit)
            begin
                if (is_insert)
                begin
                    res_slot_reg <= SLOT_W'(probe_reg);
                end
            end
            else if (sts.last_probe)
            begin
                res_full_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_dup_reg   <= res_dup_reg;
            out_slot_reg  <= res_slot_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_full_reg, out_slot_reg, out_dup_reg,
                       out_found_reg};

endmodule

>>> sim/scoped_name_hash_index_tb.sv
// ----------------------------------------------------------------------------
// Scoped name hash index testbench
// Drives insert, find and clear beats through the slave stream, rewrites the
// table size between phases and checks every result beat against a bench mirror
// of the hash set or, for some directed rows, a fixed result. Directed rows come
// first, then random phases with bursty input and a receiver that stalls on its own.
// ----------------------------------------------------------------------------
module scoped_name_hash_index_tb;
    import snhi_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEFAULT;
    localparam int N_DIR          = 24;
    localparam int N_PHASES       = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int POOL_MAX       = 48;
    localparam int LONG_HOLD      = 500;
    localparam int TAIL_CYCLES    = 40;
    localparam int QUIET_LIMIT    = 12000;

    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] slot;
        logic              dup;
        logic              found;
    } hash_result_t;

    typedef struct packed {
        logic [SCOPE_W-1:0] scope;
        logic [NAME_W-1:0]  name;
    } name_key_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [OP_W-1:0]    op;
        logic [SCOPE_W-1:0] scope;
        logic [NAME_W-1:0]  name;
        int                 reps;
        bit                 typed;
        hash_result_t       want;
    } dir_row_t;

    localparam hash_result_t RES_NONE = '0;
    localparam hash_result_t RES_FULL = '{full: 1'b1, default: '0};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SIZE_W-1:0]      cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [SCOPE_W-1:0] mirror_scope [DEPTH];
    logic [NAME_W-1:0]  mirror_key [DEPTH];
    bit                 mirror_dup [DEPTH];
    logic [SIZE_W-1:0]  size_shadow;

    hash_result_t pending_results [$];
    name_key_t    key_pool [$];
    dir_row_t     dir_rows [N_DIR];
    int           errors;
    int           burst_left;
    int           quiet_cycles;

    logic long_hold_arm = 1'b0;
    bit   hold_done;
    int   hold_left;
    int   pattern_left;
    int   stall_pct;
    logic ready_nxt;

    scoped_name_hash_index #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] mix_key(logic [63:0] scope, logic [31:0] name);
        logic [63:0] v;
        v = scope;
        v = v ^ ({32'd0, name} + GOLDEN_STEP + (v << COMBINE_SHL) + (v >> COMBINE_SHR));
        v = v ^ (v >> FOLD_A);
        v = v * MIX_MUL_A;
        v = v ^ (v >> FOLD_B);
        v = v * MIX_MUL_B;
        return v ^ (v >> FOLD_C);
    endfunction

    task automatic hash_set_apply(input logic [OP_W-1:0] op, input logic [SCOPE_W-1:0] scope,
                                  input logic [NAME_W-1:0] name, output hash_result_t res);
        int          cap;
        int          lg;
        int unsigned count;
        int unsigned mask;
        int unsigned slot;
        int unsigned visited;
        logic [NAME_W-1:0] key;
        bit          empty_hit;
        bit          match;
        res = RES_NONE;
        if (op == OP_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) begin
                mirror_scope[i] = '0;
                mirror_key[i]   = '0;
                mirror_dup[i]   = 1'b0;
            end
        end else if (op != OP_RESERVED && name != NAME_RESERVED) begin
            cap = 0;
            while (cap < SIZE_LOG2_MAX && (1 << (cap + 1)) <= DEPTH)
                cap++;
            lg = int'(size_shadow);
            if (lg < SIZE_LOG2_MIN)
                lg = SIZE_LOG2_MIN;
            if (lg > cap)
                lg = cap;
            count     = 1 << lg;
            mask      = count - 1;
            key       = name + NAME_W'(1);
            slot      = 32'(mix_key(scope, name) & 64'(mask));
            visited   = 0;
            empty_hit = 1'b0;
            match     = 1'b0;
            while (visited < count && !empty_hit && !match) begin
                if (mirror_key[slot] == '0)
                    empty_hit = 1'b1;
                else if (mirror_key[slot] == key && mirror_scope[slot] == scope)
                    match = 1'b1;
                else
                begin
                    slot = (slot + 1) & mask;
                    visited++;
                end
            end
            if (match) begin
                if (op == OP_INSERT)
                    mirror_dup[slot] = 1'b1;
                res.found = 1'b1;
                res.dup   = mirror_dup[slot];
                res.slot  = slot[SLOT_W-1:0];
            end else if (empty_hit) begin
                if (op == OP_INSERT) begin
                    mirror_scope[slot] = scope;
                    mirror_key[slot]   = key;
                    mirror_dup[slot]   = 1'b0;
                    res.slot           = slot[SLOT_W-1:0];
                end
            end else begin
                res.full = 1'b1;
            end
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SCOPE_W-1:0] scope,
                             input logic [NAME_W-1:0] name, input bit typed,
                             input hash_result_t want);
        int           gap;
        hash_result_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({name, scope, op});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hash_set_apply(op, scope, name, res);
        pending_results.push_back(typed ? want : res);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_shadow = value;
    endtask

    function automatic name_key_t fresh_key();
        name_key_t k;
        case ($urandom_range(0, 3))
            0: k.scope = {$urandom, $urandom};
            1: k.scope = 64'($urandom_range(0, 15));
            2: k.scope = ~64'($urandom_range(0, 15));
            default: k.scope = {1'($urandom_range(0, 1)), 31'd0,
                                1'($urandom_range(0, 1)), 31'd0};
        endcase
        case ($urandom_range(0, 3))
            0: k.name = $urandom_range(0, 7);
            1: k.name = 32'hFFFF_FFFE - $urandom_range(0, 7);
            default: k.name = $urandom_range(0, 32'hFFFF_FFFE);
        endcase
        return k;
    endfunction

    task automatic random_item();
        name_key_t       k;
        logic [OP_W-1:0] op;
        int              r;
        bit              reuse;
        r = $urandom_range(0, 99);
        if (r < 1) begin
            key_pool.delete();
            send_item(OP_CLEAR, {$urandom, $urandom}, $urandom, 1'b0, RES_NONE);
        end else if (r < 3) begin
            send_item(OP_RESERVED, {$urandom, $urandom}, $urandom, 1'b0, RES_NONE);
        end else if (r < 6) begin
            op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_FIND;
            send_item(op, {$urandom, $urandom}, NAME_RESERVED, 1'b0, RES_NONE);
        end else begin
            op    = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_FIND;
            reuse = key_pool.size() > 0 && $urandom_range(0, 1) == 1;
            if (reuse) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else begin
                k = fresh_key();
                if (op == OP_INSERT) begin
                    key_pool.push_back(k);
                    if (key_pool.size() > POOL_MAX)
                        void'(key_pool.pop_front());
                end
            end
            send_item(op, k.scope, k.name, 1'b0, RES_NONE);
        end
    endtask

    task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                hash_result_t want;
                hash_result_t got;
                want = pending_results.pop_front();
                got  = hash_result_t'(m_tdata[SLOT_W+2:0]);
                check_field("found", want.found, got.found);
                check_field("duplicated", want.dup, got.dup);
                check_field("slot_index", want.slot, got.slot);
                check_field("table_full", want.full, got.full);
            end
        end
    end

    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            ready_nxt = 1'b0;
        end else if (long_hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            ready_nxt = 1'b0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            ready_nxt = $urandom_range(0, 99) >= stall_pct;
        end
        m_tready <= ready_nxt;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("FAIL scoped_name_hash_index");
            $finish;
        end
    end

    initial begin
        logic [SIZE_W-1:0] phase_sizes [N_PHASES];
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        errors       = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        hold_done    = 1'b0;
        hold_left    = 0;
        pattern_left = 0;
        stall_pct    = 0;
        size_shadow  = SIZE_LOG2_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            mirror_scope[i] = '0;
            mirror_key[i]   = '0;
            mirror_dup[i]   = 1'b0;
        end
        phase_sizes = '{4'd4, 4'd0, 4'd10, 4'd5, 4'd15, 4'd3, 4'd6, 4'd4, 4'd11, 4'd8, 4'd7, 4'd4};
        dir_rows = '{
            '{4'd10, OP_FIND,     64'd0,         32'd0,         1,  1'b1, RES_NONE},
            '{4'd10, OP_INSERT,   64'd0,         32'd0,         1,  1'b0, RES_NONE},
            '{4'd10, OP_INSERT,   64'd0,         32'd0,         1,  1'b0, RES_NONE},
            '{4'd10, OP_FIND,     64'd0,         32'd0,         1,  1'b0, RES_NONE},
            '{4'd10, OP_INSERT,   '1,            32'hFFFF_FFFE, 1,  1'b0, RES_NONE},
            '{4'd10, OP_INSERT,   '1,            32'hFFFF_FFFE, 1,  1'b0, RES_NONE},
            '{4'd10, OP_FIND,     '1,            32'hFFFF_FFFE, 1,  1'b0, RES_NONE},
            '{4'd10, OP_FIND,     '1,            32'd0,         1,  1'b1, RES_NONE},
            '{4'd10, OP_INSERT,   64'h5555_5555_5555_5555, NAME_RESERVED, 1, 1'b1, RES_NONE},
            '{4'd10, OP_FIND,     64'd0,         NAME_RESERVED, 1,  1'b1, RES_NONE},
            '{4'd10, OP_RESERVED, 64'd0,         32'd0,         1,  1'b1, RES_NONE},
            '{4'd10, OP_CLEAR,    '1,            '1,            1,  1'b1, RES_NONE},
            '{4'd10, OP_FIND,     64'd0,         32'd0,         1,  1'b1, RES_NONE},
            '{4'd0,  OP_INSERT,   64'h100,       32'd7,         16, 1'b0, RES_NONE},
            '{4'd0,  OP_INSERT,   64'h110,       32'd7,         1,  1'b1, RES_FULL},
            '{4'd0,  OP_FIND,     64'hDEAD,      32'd9,         1,  1'b1, RES_FULL},
            '{4'd0,  OP_FIND,     64'h105,       32'd7,         1,  1'b0, RES_NONE},
            '{4'd0,  OP_INSERT,   64'h10A,       32'd7,         1,  1'b0, RES_NONE},
            '{4'd15, OP_FIND,     64'h105,       32'd7,         1,  1'b0, RES_NONE},
            '{4'd15, OP_INSERT,   64'h77,        32'd3,         1,  1'b0, RES_NONE},
            '{4'd3,  OP_FIND,     64'h77,        32'd3,         1,  1'b0, RES_NONE},
            '{4'd4,  OP_CLEAR,    64'd0,         32'd0,         1,  1'b1, RES_NONE},
            '{4'd4,  OP_FIND,     64'h105,       32'd7,         1,  1'b1, RES_NONE},
            '{4'd10, OP_INSERT,   64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 1, 1'b0, RES_NONE}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].size != size_shadow)
                write_size(dir_rows[r].size);
            for (int i = 0; i < dir_rows[r].reps; i++)
                send_item(dir_rows[r].op, dir_rows[r].scope + 64'(i), dir_rows[r].name,
                          dir_rows[r].typed, dir_rows[r].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_size(phase_sizes[p]);
            if (p == 1)
                long_hold_arm <= 1'b1;
            if ($urandom_range(0, 1) == 1) begin
                key_pool.delete();
                send_item(OP_CLEAR, '0, '0, 1'b0, RES_NONE);
            end
            repeat (ITEMS_PER_PHASE) random_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS scoped_name_hash_index");
        else
            $display("FAIL scoped_name_hash_index");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/snhi_pkg.sv
rtl/core/snhi_ctrl.sv
rtl/core/snhi_datapath.sv
rtl/core/scoped_name_hash_index.sv
sim/scoped_name_hash_index_tb.sv
